// ----- hdl/cpa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cpa_pkg: shared types, constants and step functions
// Transaction types, the arctangent table and the per-stage arithmetic steps
// of the circle point pipeline.
// ----------------------------------------------------------------------------
package cpa_pkg;

	localparam int TRIG_ITERATIONS = 24;
	localparam int ROM_SIZE        = 30;
	localparam int SQRT_STEPS      = 32;
	localparam int DIV_STEPS       = 31;

	localparam logic [1:0] CASE_GENERAL  = 2'd0;
	localparam logic [1:0] CASE_VERTICAL = 2'd1;
	localparam logic [1:0] CASE_ZERO     = 2'd2;

	// Angle constants in Q28
	localparam logic signed [32:0] PI28 = 33'sd843314857;
	localparam logic signed [32:0] HP28 = 33'sd421657428;
	localparam logic signed [32:0] TP28 = 33'sd1686629713;

	localparam logic signed [33:0] CORDIC_GAIN30 = 34'sd652032874;
	localparam logic signed [33:0] ONE30         = 34'sd1073741824;

	// atan(2^-i) in Q28
	localparam logic signed [31:0] ATAN_ROM [ROM_SIZE] = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422,  32'sd8385879,   32'sd4193963,  32'sd2097109,
		32'sd1048571,   32'sd524287,    32'sd262144,   32'sd131072,
		32'sd65536,     32'sd32768,     32'sd16384,    32'sd8192,
		32'sd4096,      32'sd2048,      32'sd1024,     32'sd512,
		32'sd256,       32'sd128,       32'sd64,       32'sd32,
		32'sd16,        32'sd8,         32'sd4,        32'sd2,
		32'sd1,         32'sd1
	};

	typedef struct packed {
		logic signed [31:0] axis_x;
		logic signed [31:0] axis_y;
		logic signed [31:0] axis_z;
		logic [30:0]        radius;
		logic signed [31:0] angle;
	} item_t;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [1:0]         axis_case;
	} result_t;

	typedef struct packed {
		logic [1:0]  axis_case;
		logic        neg_vx;
		logic        neg_vy;
		logic        neg_uz;
		logic [30:0] radius;
	} meta_t;

	typedef struct packed {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [31:0] a;
		logic               neg;
	} cor_t;

	typedef struct packed {
		logic signed [31:0] c;
		logic signed [31:0] s;
	} trig_t;

	typedef struct packed {
		logic [31:0] hx;
		logic [31:0] hy;
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
	} shf_t;

	typedef struct packed {
		logic [31:0] hx;
		logic [31:0] hy;
		logic [31:0] fz;
	} gx_t;

	typedef struct packed {
		logic [63:0] hx2;
		logic [63:0] hy2;
		logic [63:0] fx2;
		logic [63:0] fy2;
		logic [63:0] fz2;
	} sqr_t;

	typedef struct packed {
		logic [63:0] v;
		logic [34:0] rem;
		logic [31:0] root;
	} sqrt_t;

	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] den;
		logic [30:0] q;
	} div_t;

	function automatic logic [31:0] mag32(input logic signed [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	// shift that brings the leading one to bit 30 or above
	function automatic logic [4:0] norm_shift(input logic [31:0] m);
		logic [4:0] sh;
		sh = 5'd31;
		for (int b = 0; b < 30; b++) begin
			if (m[b]) sh = 5'(30 - b);
		end
		if (m[31] || m[30]) sh = 5'd0;
		return sh;
	endfunction

	function automatic cor_t cordic_step(input cor_t c, input int i);
		cor_t n;
		logic signed [33:0] x0, y0, xs, ys;
		n  = c;
		x0 = c.x;
		y0 = c.y;
		xs = x0 >>> i;
		ys = y0 >>> i;
		if (!c.a[31]) begin
			n.x = x0 - ys;
			n.y = y0 + xs;
			n.a = c.a - ATAN_ROM[5'(i)];
		end else begin
			n.x = x0 + ys;
			n.y = y0 - xs;
			n.a = c.a + ATAN_ROM[5'(i)];
		end
		return n;
	endfunction

	function automatic sqrt_t sqrt_step(input sqrt_t s);
		sqrt_t n;
		logic [34:0] r2, trial;
		r2    = {s.rem[32:0], s.v[63:62]};
		trial = {1'b0, s.root, 2'b01};
		n.v   = {s.v[61:0], 2'b00};
		if (r2 >= trial) begin
			n.rem  = r2 - trial;
			n.root = {s.root[30:0], 1'b1};
		end else begin
			n.rem  = r2;
			n.root = {s.root[30:0], 1'b0};
		end
		return n;
	endfunction

	function automatic div_t div_step(input div_t s);
		div_t n;
		logic [32:0] r1;
		logic ge;
		ge    = s.rem >= {1'b0, s.den};
		r1    = ge ? (s.rem - {1'b0, s.den}) : s.rem;
		n.rem = {r1[31:0], 1'b0};
		n.den = s.den;
		n.q   = {s.q[29:0], ge};
		return n;
	endfunction

	function automatic logic signed [63:0] round30(input logic signed [63:0] v);
		return (v + 64'sd536870912) >>> 30;
	endfunction

	function automatic logic signed [31:0] clamp_one(input logic signed [33:0] v);
		if (v > ONE30) return 32'sd1073741824;
		if (v < -ONE30) return -32'sd1073741824;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// ----- hdl/circle_point_around_axis.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circle_point_around_axis: point on a circle perpendicular to an axis
// Returns r*(V cos f + W sin f) for the frame built around an axis vector,
// with vertical and zero axes handled as special cases. Fixed-point, saturated.
// ----------------------------------------------------------------------------
//
// Channel   Ports                 Transfer
// --------  --------------------  --------------------------------------------
// command   start, busy, item     accepted on a rising edge with start && !busy
// result    done, result          one cycle with done high, taken at that edge
//
// Throughput is one transaction per clock; busy is held low.
// The pipeline has 5 front-end stages, 32 square-root stages, 31 divider
// stages and 7 back-end stages (the CORDIC runs in parallel with the roots).
// Reset clears the valid chain only; datapath registers run free.
// Nothing stalls: the pipeline advances every clock and each done pulse is
// the result of the oldest accepted transaction not yet returned.
//
module circle_point_around_axis (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  cpa_pkg::item_t     item,
	output logic               done,
	output cpa_pkg::result_t   result
);
	import cpa_pkg::*;

	localparam int ST_TRIG = 3 + TRIG_ITERATIONS;    // clamped cos/sin register
	localparam int ST_DIV0 = 6 + SQRT_STEPS;         // first divider step
	localparam int ST_SIGN = ST_DIV0 + DIV_STEPS;    // signed direction ratios
	localparam int ST_DP   = ST_SIGN + 3;            // direction products
	localparam int ST_DS   = ST_DP + 1;              // direction sums
	localparam int ST_RP   = ST_DP + 2;              // radius products
	localparam int ST_OUT  = ST_DP + 3;              // result register

	logic [ST_OUT:1] vld_s;
	meta_t meta_s [1:ST_OUT-1];

	// stage 1: magnitudes, case, angle wrap
	logic [31:0]        mx_s1, my_s1, mz_s1;
	logic signed [31:0] ang_s1;
	logic signed [32:0] ang_in, ang_wrap;
	meta_t              meta_in;

	// stage 2: maxima and angle fold
	logic [31:0]        mx_s2, my_s2, mz_s2, mh_s2, ma_s2;
	logic signed [31:0] ang_s2;
	logic               neg_s2;
	logic [31:0]        mh_w, ma_w;
	logic signed [32:0] ang_fold;
	logic               neg_fold;

	// stage 3..: normalized components, squares, sums
	shf_t        sh_s3;
	logic [4:0]  sh_h, sh_a;
	sqr_t        sqr_s4;
	gx_t         gx_s [4:ST_DIV0-1];
	logic [63:0] sum_h_s5, sum_fh_s5, sum_f_s5;

	// CORDIC lane
	cor_t  cor_init;
	cor_t  cor_s [TRIG_ITERATIONS];
	trig_t cs_s  [ST_TRIG:ST_DP];

	// square root and divider lanes
	sqrt_t sqh_s  [SQRT_STEPS];
	sqrt_t sqf_s  [SQRT_STEPS];
	sqrt_t sqfh_s [SQRT_STEPS];
	div_t  dvx_s  [DIV_STEPS];
	div_t  dvy_s  [DIV_STEPS];
	div_t  duz_s  [DIV_STEPS];
	div_t  dwz_s  [DIV_STEPS];

	// back end
	logic signed [31:0] vx_s69, vy_s69, uz_s69, wz_s69;
	logic signed [63:0] pwx_s70, pwy_s70;
	logic signed [31:0] vx_s70, vy_s70, wz_s70;
	logic signed [31:0] wx_s71, wy_s71, vx_s71, vy_s71, wz_s71;
	logic signed [63:0] rwx, rwy;
	logic signed [63:0] pxc_s72, pxs_s72, pyc_s72, pys_s72, pzs_s72;
	logic signed [63:0] rdx, rdy, rdz;
	logic signed [32:0] dx_w, dy_w, dz_w;
	logic signed [32:0] dx_s73, dy_s73, dz_s73;
	logic signed [63:0] prx_s74, pry_s74, prz_s74;
	result_t            result_s75;

	assign busy = 1'b0;

	// Advance the valid chain; an accepted command enters stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[ST_OUT-1:1], start & ~busy};
		end
	end

	// ---- stage 1 ----
	always_comb begin
		meta_in.radius = item.radius;
		meta_in.neg_vx = !item.axis_y[31] && (item.axis_y != '0);
		meta_in.neg_vy = item.axis_x[31];
		meta_in.neg_uz = item.axis_z[31];
		if ((item.axis_x != '0) || (item.axis_y != '0)) begin
			meta_in.axis_case = CASE_GENERAL;
		end else if (item.axis_z != '0) begin
			meta_in.axis_case = CASE_VERTICAL;
		end else begin
			meta_in.axis_case = CASE_ZERO;
		end
		// Bring the angle into [-pi, pi]; one turn is always enough.
		ang_in = $signed({item.angle[31], item.angle});
		if (ang_in > PI28) begin
			ang_wrap = ang_in - TP28;
		end else if (ang_in < -PI28) begin
			ang_wrap = ang_in + TP28;
		end else begin
			ang_wrap = ang_in;
		end
	end

	always_ff @(posedge clk) begin
		mx_s1  <= mag32(item.axis_x);
		my_s1  <= mag32(item.axis_y);
		mz_s1  <= mag32(item.axis_z);
		ang_s1 <= ang_wrap[31:0];
	end

	// Carry the per-transaction tags down the whole pipeline.
	always_ff @(posedge clk) begin
		meta_s[1] <= meta_in;
		for (int k = 2; k < ST_OUT; k++) begin
			meta_s[k] <= meta_s[k-1];
		end
	end

	// ---- stage 2 ----
	always_comb begin
		mh_w = (mx_s1 > my_s1) ? mx_s1 : my_s1;
		ma_w = (mh_w > mz_s1) ? mh_w : mz_s1;
		// Fold into [-pi/2, pi/2] with a half turn that flips cos and sin.
		ang_fold = $signed({ang_s1[31], ang_s1});
		neg_fold = 1'b0;
		if (ang_fold > HP28) begin
			ang_fold = ang_fold - PI28;
			neg_fold = 1'b1;
		end else if (ang_fold < -HP28) begin
			ang_fold = ang_fold + PI28;
			neg_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		mx_s2  <= mx_s1;
		my_s2  <= my_s1;
		mz_s2  <= mz_s1;
		mh_s2  <= mh_w;
		ma_s2  <= ma_w;
		ang_s2 <= ang_fold[31:0];
		neg_s2 <= neg_fold;
	end

	// ---- stage 3: normalize the horizontal pair and the full vector ----
	assign sh_h = norm_shift(mh_s2);
	assign sh_a = norm_shift(ma_s2);

	always_ff @(posedge clk) begin
		sh_s3.hx <= mx_s2 << sh_h;
		sh_s3.hy <= my_s2 << sh_h;
		sh_s3.fx <= mx_s2 << sh_a;
		sh_s3.fy <= my_s2 << sh_a;
		sh_s3.fz <= mz_s2 << sh_a;
	end

	// ---- stage 4: squares ----
	always_ff @(posedge clk) begin
		sqr_s4.hx2 <= sh_s3.hx * sh_s3.hx;
		sqr_s4.hy2 <= sh_s3.hy * sh_s3.hy;
		sqr_s4.fx2 <= sh_s3.fx * sh_s3.fx;
		sqr_s4.fy2 <= sh_s3.fy * sh_s3.fy;
		sqr_s4.fz2 <= sh_s3.fz * sh_s3.fz;
	end

	// Hold the numerators until the divider needs them.
	always_ff @(posedge clk) begin
		gx_s[4] <= '{hx: sh_s3.hx, hy: sh_s3.hy, fz: sh_s3.fz};
		for (int k = 5; k < ST_DIV0; k++) begin
			gx_s[k] <= gx_s[k-1];
		end
	end

	// ---- stage 5: sums of squares ----
	always_ff @(posedge clk) begin
		sum_h_s5  <= sqr_s4.hx2 + sqr_s4.hy2;
		sum_fh_s5 <= sqr_s4.fx2 + sqr_s4.fy2;
		sum_f_s5  <= sqr_s4.fx2 + sqr_s4.fy2 + sqr_s4.fz2;
	end

	// ---- square roots: one result bit per stage ----
	genvar gi;
	for (gi = 0; gi < SQRT_STEPS; gi++) begin : g_sqrt
		if (gi == 0) begin : g_first
			always_ff @(posedge clk) begin
				sqh_s[gi]  <= sqrt_step('{v: sum_h_s5,  rem: '0, root: '0});
				sqf_s[gi]  <= sqrt_step('{v: sum_f_s5,  rem: '0, root: '0});
				sqfh_s[gi] <= sqrt_step('{v: sum_fh_s5, rem: '0, root: '0});
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				sqh_s[gi]  <= sqrt_step(sqh_s[gi-1]);
				sqf_s[gi]  <= sqrt_step(sqf_s[gi-1]);
				sqfh_s[gi] <= sqrt_step(sqfh_s[gi-1]);
			end
		end
	end

	// ---- Q30 ratios: one quotient bit per stage ----
	for (gi = 0; gi < DIV_STEPS; gi++) begin : g_div
		if (gi == 0) begin : g_first
			always_ff @(posedge clk) begin
				dvx_s[gi] <= div_step('{rem: {1'b0, gx_s[ST_DIV0-1].hy},
					den: sqh_s[SQRT_STEPS-1].root, q: '0});
				dvy_s[gi] <= div_step('{rem: {1'b0, gx_s[ST_DIV0-1].hx},
					den: sqh_s[SQRT_STEPS-1].root, q: '0});
				duz_s[gi] <= div_step('{rem: {1'b0, gx_s[ST_DIV0-1].fz},
					den: sqf_s[SQRT_STEPS-1].root, q: '0});
				dwz_s[gi] <= div_step('{rem: {1'b0, sqfh_s[SQRT_STEPS-1].root},
					den: sqf_s[SQRT_STEPS-1].root, q: '0});
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				dvx_s[gi] <= div_step(dvx_s[gi-1]);
				dvy_s[gi] <= div_step(dvy_s[gi-1]);
				duz_s[gi] <= div_step(duz_s[gi-1]);
				dwz_s[gi] <= div_step(dwz_s[gi-1]);
			end
		end
	end

	// ---- CORDIC: one rotation per stage, from stage 3 on ----
	always_comb begin
		cor_init.x   = CORDIC_GAIN30;
		cor_init.y   = '0;
		cor_init.a   = ang_s2;
		cor_init.neg = neg_s2;
	end

	for (gi = 0; gi < TRIG_ITERATIONS; gi++) begin : g_cor
		if (gi == 0) begin : g_first
			always_ff @(posedge clk) begin
				cor_s[gi] <= cordic_step(cor_init, gi);
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				cor_s[gi] <= cordic_step(cor_s[gi-1], gi);
			end
		end
	end

	// Clamp to unit range, undo the half turn, then hold until the back end.
	always_ff @(posedge clk) begin
		if (cor_s[TRIG_ITERATIONS-1].neg) begin
			cs_s[ST_TRIG].c <= -clamp_one(cor_s[TRIG_ITERATIONS-1].x);
			cs_s[ST_TRIG].s <= -clamp_one(cor_s[TRIG_ITERATIONS-1].y);
		end else begin
			cs_s[ST_TRIG].c <= clamp_one(cor_s[TRIG_ITERATIONS-1].x);
			cs_s[ST_TRIG].s <= clamp_one(cor_s[TRIG_ITERATIONS-1].y);
		end
		for (int k = ST_TRIG + 1; k <= ST_DP; k++) begin
			cs_s[k] <= cs_s[k-1];
		end
	end

	// ---- signs of V and U ----
	always_ff @(posedge clk) begin
		vx_s69 <= meta_s[ST_SIGN-1].neg_vx ? -$signed({1'b0, dvx_s[DIV_STEPS-1].q})
			: $signed({1'b0, dvx_s[DIV_STEPS-1].q});
		vy_s69 <= meta_s[ST_SIGN-1].neg_vy ? -$signed({1'b0, dvy_s[DIV_STEPS-1].q})
			: $signed({1'b0, dvy_s[DIV_STEPS-1].q});
		uz_s69 <= meta_s[ST_SIGN-1].neg_uz ? -$signed({1'b0, duz_s[DIV_STEPS-1].q})
			: $signed({1'b0, duz_s[DIV_STEPS-1].q});
		wz_s69 <= $signed({1'b0, dwz_s[DIV_STEPS-1].q});
	end

	// ---- W = U x V: products, then rounding ----
	always_ff @(posedge clk) begin
		pwx_s70 <= uz_s69 * vy_s69;
		pwy_s70 <= uz_s69 * vx_s69;
		vx_s70  <= vx_s69;
		vy_s70  <= vy_s69;
		wz_s70  <= wz_s69;
	end

	assign rwx = round30(pwx_s70);
	assign rwy = round30(pwy_s70);

	always_ff @(posedge clk) begin
		wx_s71 <= -rwx[31:0];
		wy_s71 <= rwy[31:0];
		vx_s71 <= vx_s70;
		vy_s71 <= vy_s70;
		wz_s71 <= wz_s70;
	end

	// ---- direction products ----
	always_ff @(posedge clk) begin
		pxc_s72 <= vx_s71 * cs_s[ST_DP-1].c;
		pxs_s72 <= wx_s71 * cs_s[ST_DP-1].s;
		pyc_s72 <= vy_s71 * cs_s[ST_DP-1].c;
		pys_s72 <= wy_s71 * cs_s[ST_DP-1].s;
		pzs_s72 <= wz_s71 * cs_s[ST_DP-1].s;
	end

	// ---- direction sums and axis case selection ----
	assign rdx = round30(pxc_s72 + pxs_s72);
	assign rdy = round30(pyc_s72 + pys_s72);
	assign rdz = round30(pzs_s72);

	always_comb begin
		case (meta_s[ST_DS-1].axis_case)
			CASE_GENERAL: begin
				dx_w = rdx[32:0];
				dy_w = rdy[32:0];
				dz_w = rdz[32:0];
			end
			CASE_VERTICAL: begin
				dx_w = {cs_s[ST_DP].c[31], cs_s[ST_DP].c};
				dy_w = {cs_s[ST_DP].s[31], cs_s[ST_DP].s};
				dz_w = '0;
			end
			default: begin
				dx_w = '0;
				dy_w = '0;
				dz_w = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		dx_s73 <= dx_w;
		dy_s73 <= dy_w;
		dz_s73 <= dz_w;
	end

	// ---- scale by radius ----
	always_ff @(posedge clk) begin
		prx_s74 <= $signed({1'b0, meta_s[ST_RP-1].radius}) * dx_s73;
		pry_s74 <= $signed({1'b0, meta_s[ST_RP-1].radius}) * dy_s73;
		prz_s74 <= $signed({1'b0, meta_s[ST_RP-1].radius}) * dz_s73;
	end

	// ---- round, saturate, present ----
	always_ff @(posedge clk) begin
		result_s75.point_x   <= sat32(round30(prx_s74));
		result_s75.point_y   <= sat32(round30(pry_s74));
		result_s75.point_z   <= sat32(round30(prz_s74));
		result_s75.axis_case <= meta_s[ST_OUT-1].axis_case;
	end

	assign result = result_s75;
	assign done   = vld_s[ST_OUT];

	// ---- assertions ----
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, ST_OUT))
		else $error("result strobe without a matching command");

	a_cmd_gets_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##ST_OUT done)
		else $error("command did not produce a result");

	a_zero_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.axis_case == CASE_ZERO) |->
		(result.point_x == '0 && result.point_y == '0 && result.point_z == '0))
		else $error("zero axis gave a nonzero point");

	a_vertical_flat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.axis_case == CASE_VERTICAL) |-> (result.point_z == '0))
		else $error("vertical axis gave a nonzero z");

endmodule
`default_nettype wire
